// ===== rtl/core/gaussian_blur_square_kernel_2d_top_macros.svh =====
// assertion helpers for the blur block checker
`ifndef GAUSSIAN_BLUR_SQUARE_KERNEL_2D_TOP_MACROS_SVH
`define GAUSSIAN_BLUR_SQUARE_KERNEL_2D_TOP_MACROS_SVH

// same-cycle implication, quiet while in reset
`define GBK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define GBK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define GBK_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gbk_pkg.sv =====
package gbk_pkg;

  localparam int MAX_RADIUS = 3;
  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 16;
  localparam int ROW_LIMIT  = 1024;
  localparam int WIN        = 2 * MAX_RADIUS + 1;
  localparam int LINES      = 2 * MAX_RADIUS;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(ROW_LIMIT);
  localparam int SIZE_W     = 11;
  localparam int RAD_W      = 2;
  localparam int WGT_W      = 17;
  localparam int PROD_W     = PIXEL_BITS + WGT_W;
  localparam int ROWSUM_W   = PROD_W + 3;
  localparam int SUM_W      = PROD_W + 7;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [RAD_W-1:0]      rad_t;
  typedef logic [WGT_W-1:0]      wgt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  // position and result tags of one pixel, carried down the pipeline
  typedef struct packed {
    col_t col;
    logic emit;
    logic last;
    col_t ctr_col;
    row_t ctr_row;
    rad_t radius;
  } pos_t;

  // unsigned Q1.16 weights by radius, |dy|, |dx|
  localparam wgt_t KERN [4][4][4] = '{
    '{'{17'd65536, 17'd0, 17'd0, 17'd0}, '{17'd0, 17'd0, 17'd0, 17'd0},
      '{17'd0, 17'd0, 17'd0, 17'd0},     '{17'd0, 17'd0, 17'd0, 17'd0}},
    '{'{17'd21752, 17'd8002, 17'd0, 17'd0}, '{17'd8002, 17'd2944, 17'd0, 17'd0},
      '{17'd0, 17'd0, 17'd0, 17'd0},        '{17'd0, 17'd0, 17'd0, 17'd0}},
    '{'{17'd10624, 17'd6444, 17'd1438, 17'd0}, '{17'd6444, 17'd3908, 17'd872, 17'd0},
      '{17'd1438, 17'd872, 17'd195, 17'd0},    '{17'd0, 17'd0, 17'd0, 17'd0}},
    '{'{17'd7000, 17'd5016, 17'd1845, 17'd348}, '{17'd5016, 17'd3594, 17'd1322, 17'd250},
      '{17'd1845, 17'd1322, 17'd486, 17'd92},   '{17'd348, 17'd250, 17'd92, 17'd17}}
  };

  // weight of window tap (i, j) for radius r; taps left of or above the window are zero
  function automatic wgt_t win_weight(rad_t r, int i, int j);
    int lo;
    int ctr;
    int di;
    int dj;
    logic [1:0] di_s;
    logic [1:0] dj_s;
    lo  = LINES - 2 * int'(r);
    ctr = LINES - int'(r);
    di  = (i > ctr) ? i - ctr : ctr - i;
    dj  = (j > ctr) ? j - ctr : ctr - j;
    di_s = di[1:0];
    dj_s = dj[1:0];
    if (i < lo || j < lo) begin
      return '0;
    end
    return KERN[r][di_s][dj_s];
  endfunction

endpackage

// ===== rtl/core/gbk_stream_if.sv =====
interface gbk_in_if;
  logic                 valid;
  logic                 ready;
  gbk_pkg::pix_t        pixel_value;
  logic                 frame_start;
  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface gbk_out_if;
  logic                 valid;
  logic                 ready;
  gbk_pkg::pix_t        blurred_value;
  gbk_pkg::col_t        center_col;
  gbk_pkg::row_t        center_row;
  logic                 frame_last;
  modport source (output valid, output blurred_value, output center_col,
                  output center_row, output frame_last, input ready);
  modport sink   (input valid, input blurred_value, input center_col,
                  input center_row, input frame_last, output ready);
endinterface

interface gbk_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [gbk_pkg::CFG_IDX_W-1:0]      index;
  logic [gbk_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/gbk_ram.sv =====
module gbk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/gbk_ctrl.sv =====
module gbk_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  gbk_cfg_if.sink        cfg_ch,
  input  logic           accept,
  input  logic           frame_start,
  output gbk_pkg::pos_t  pos
);

  gbk_pkg::rad_t  radius_r;
  gbk_pkg::size_t width_r;
  gbk_pkg::size_t height_r;
  gbk_pkg::col_t  col_r, col_nxt;
  gbk_pkg::row_t  row_r, row_nxt;

  gbk_pkg::size_t w, h, c0, r0, c1, r1, r2, cn, rn, two_r, rad_ext;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (width_r == '0) begin
      w = gbk_pkg::SIZE_W'(1);
    end else if (width_r > gbk_pkg::SIZE_W'(gbk_pkg::MAX_WIDTH)) begin
      w = gbk_pkg::SIZE_W'(gbk_pkg::MAX_WIDTH);
    end else begin
      w = width_r;
    end
    if (height_r == '0) begin
      h = gbk_pkg::SIZE_W'(1);
    end else if (height_r > gbk_pkg::SIZE_W'(gbk_pkg::ROW_LIMIT)) begin
      h = gbk_pkg::SIZE_W'(gbk_pkg::ROW_LIMIT);
    end else begin
      h = height_r;
    end

    c0 = frame_start ? '0 : gbk_pkg::SIZE_W'(col_r);
    r0 = frame_start ? '0 : gbk_pkg::SIZE_W'(row_r);
    // a shrunk size can leave the position out of range
    if (c0 >= w) begin
      c1 = '0;
      r1 = r0 + gbk_pkg::SIZE_W'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= h) ? '0 : r1;

    rad_ext = gbk_pkg::SIZE_W'(radius_r);
    two_r   = rad_ext << 1;

    pos.col     = c1[gbk_pkg::COL_W-1:0];
    pos.emit    = (c1 >= two_r) && (r2 >= two_r);
    pos.last    = (c1 == w - gbk_pkg::SIZE_W'(1)) && (r2 == h - gbk_pkg::SIZE_W'(1));
    pos.ctr_col = gbk_pkg::COL_W'(c1 - rad_ext);
    pos.ctr_row = gbk_pkg::ROW_W'(r2 - rad_ext);
    pos.radius  = radius_r;

    cn = c1 + gbk_pkg::SIZE_W'(1);
    rn = r2 + gbk_pkg::SIZE_W'(1);
    if (cn >= w) begin
      col_nxt = '0;
      row_nxt = (rn >= h) ? '0 : rn[gbk_pkg::ROW_W-1:0];
    end else begin
      col_nxt = cn[gbk_pkg::COL_W-1:0];
      row_nxt = r2[gbk_pkg::ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= gbk_pkg::RAD_W'(1);
      width_r  <= gbk_pkg::SIZE_W'(gbk_pkg::MAX_WIDTH);
      height_r <= gbk_pkg::SIZE_W'(gbk_pkg::ROW_LIMIT);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          gbk_pkg::CFG_RADIUS: radius_r <= cfg_ch.data[gbk_pkg::RAD_W-1:0];
          gbk_pkg::CFG_WIDTH:  width_r  <= cfg_ch.data;
          gbk_pkg::CFG_HEIGHT: height_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/gbk_window.sv =====
module gbk_window (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           accept,
  input  gbk_pkg::pix_t  pixel,
  input  gbk_pkg::pos_t  pos,
  output gbk_pkg::pix_t  win [gbk_pkg::WIN][gbk_pkg::WIN],
  output logic           s2_v,
  output gbk_pkg::pos_t  s2_meta
);

  localparam int L = gbk_pkg::LINES;
  localparam int N = gbk_pkg::WIN;

  logic          s1_v_r;
  gbk_pkg::pos_t s1_meta_r;
  gbk_pkg::pix_t s1_pix_r;
  logic          fwd_v_r;
  gbk_pkg::pix_t fwd_r   [L];
  gbk_pkg::pix_t rdata   [L];
  gbk_pkg::pix_t colv    [N];
  gbk_pkg::pix_t win_r   [N][N];
  logic          s2_v_r;
  gbk_pkg::pos_t s2_meta_r;
  logic          wr_en;

  assign wr_en = adv && s1_v_r;

  for (genvar i = 0; i < L; i++) begin : g_line
    gbk_ram #(
      .WIDTH (gbk_pkg::PIXEL_BITS),
      .DEPTH (gbk_pkg::MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (wr_en),
      .waddr (s1_meta_r.col),
      .wdata (colv[i+1]),
      .re    (accept),
      .raddr (pos.col),
      .rdata (rdata[i])
    );
  end

  // the line just written to the same column is not yet visible in the ram read
  always_comb begin
    for (int i = 0; i < L; i++) begin
      colv[i] = fwd_v_r ? fwd_r[i] : rdata[i];
    end
    colv[N-1] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
      s2_v_r  <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= accept;
      fwd_v_r <= accept && s1_v_r && (pos.col == s1_meta_r.col);
      s2_v_r  <= s1_v_r && s1_meta_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta_r <= pos;
      s1_pix_r  <= pixel;
      s2_meta_r <= s1_meta_r;
      for (int i = 0; i < L; i++) begin
        fwd_r[i] <= colv[i+1];
      end
      if (s1_v_r) begin
        for (int i = 0; i < N; i++) begin
          for (int j = 0; j < N - 1; j++) begin
            win_r[i][j] <= win_r[i][j+1];
          end
          win_r[i][N-1] <= colv[i];
        end
      end
    end
  end

  assign win     = win_r;
  assign s2_v    = s2_v_r;
  assign s2_meta = s2_meta_r;

endmodule

// ===== rtl/core/gbk_mac.sv =====
module gbk_mac (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s2_v,
  input  gbk_pkg::pos_t  s2_meta,
  input  gbk_pkg::pix_t  win [gbk_pkg::WIN][gbk_pkg::WIN],
  gbk_out_if.source      out_ch,
  output logic           adv
);

  localparam int N = gbk_pkg::WIN;

  logic [gbk_pkg::PROD_W-1:0]   prod_r   [N][N];
  logic [gbk_pkg::ROWSUM_W-1:0] rowsum_r [N];
  logic [gbk_pkg::ROWSUM_W-1:0] rowsum   [N];
  logic [gbk_pkg::SUM_W-1:0]    total;
  logic [gbk_pkg::SUM_W-1:0]    rounded;
  logic [gbk_pkg::SUM_W-gbk_pkg::FRAC_W-1:0] scaled;
  gbk_pkg::pix_t                sat;
  logic                         s3_v_r, s4_v_r, out_v_r;
  gbk_pkg::pos_t                s3_meta_r, s4_meta_r;
  gbk_pkg::pix_t                value_r;
  gbk_pkg::col_t                col_r;
  gbk_pkg::row_t                row_r;
  logic                         last_r;

  assign adv = !out_v_r || out_ch.ready;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      rowsum[i] = '0;
      for (int j = 0; j < N; j++) begin
        rowsum[i] = rowsum[i] + gbk_pkg::ROWSUM_W'(prod_r[i][j]);
      end
    end
    total = '0;
    for (int i = 0; i < N; i++) begin
      total = total + gbk_pkg::SUM_W'(rowsum_r[i]);
    end
    rounded = total + gbk_pkg::SUM_W'(1 << (gbk_pkg::FRAC_W - 1));
    scaled  = rounded[gbk_pkg::SUM_W-1:gbk_pkg::FRAC_W];
    if (scaled > (gbk_pkg::SUM_W-gbk_pkg::FRAC_W)'({gbk_pkg::PIXEL_BITS{1'b1}})) begin
      sat = '1;
    end else begin
      sat = scaled[gbk_pkg::PIXEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r  <= s2_v;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_row
    for (genvar j = 0; j < N; j++) begin : g_tap
      gbk_pkg::wgt_t wgt;
      assign wgt = gbk_pkg::win_weight(s2_meta.radius, i, j);
      // taps outside the window may hold samples that were never written
      always_ff @(posedge clk) begin
        if (adv) begin
          if (wgt == '0) begin
            prod_r[i][j] <= '0;
          end else begin
            prod_r[i][j] <= gbk_pkg::PROD_W'(win[i][j]) * gbk_pkg::PROD_W'(wgt);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_meta_r <= s2_meta;
      s4_meta_r <= s3_meta_r;
      rowsum_r  <= rowsum;
      value_r   <= sat;
      col_r     <= s4_meta_r.ctr_col;
      row_r     <= s4_meta_r.ctr_row;
      last_r    <= s4_meta_r.last;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.blurred_value = value_r;
  assign out_ch.center_col    = col_r;
  assign out_ch.center_row    = row_r;
  assign out_ch.frame_last    = last_r;

endmodule

// ===== rtl/core/gaussian_blur_square_kernel_2d_top.sv =====
// channel   dir  handshake     payload
// in_ch     in   valid/ready   pixel_value, frame_start
// out_ch    out  valid/ready   blurred_value, center_col, center_row, frame_last
// cfg_ch    in   valid/ready   index, data (ready always high)
//
// one pixel per cycle unless the output is held; results pass s1, s2, s3, s4, out
// the line store (six single-read, single-write rams) is read on accept and written
// as the pixel leaves s1, with a bypass when two pixels in a row hit the same column
// a held output stalls the whole pipeline and drops in_ch.ready the same cycle
// reset clears position counters, registers and stage valids; the line store and
// window keep whatever they held
module gaussian_blur_square_kernel_2d_top (
  input  logic       clk,
  input  logic       rst_n,
  gbk_in_if.sink     in_ch,
  gbk_out_if.source  out_ch,
  gbk_cfg_if.sink    cfg_ch
);

  logic          adv;
  logic          accept;
  gbk_pkg::pos_t pos;
  gbk_pkg::pix_t win [gbk_pkg::WIN][gbk_pkg::WIN];
  logic          s2_v;
  gbk_pkg::pos_t s2_meta;

  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;

  gbk_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ch      (cfg_ch),
    .accept      (accept),
    .frame_start (in_ch.frame_start),
    .pos         (pos)
  );

  gbk_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .accept  (accept),
    .pixel   (in_ch.pixel_value),
    .pos     (pos),
    .win     (win),
    .s2_v    (s2_v),
    .s2_meta (s2_meta)
  );

  gbk_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .s2_v    (s2_v),
    .s2_meta (s2_meta),
    .win     (win),
    .out_ch  (out_ch),
    .adv     (adv)
  );

endmodule

// ===== rtl/core/gbk_chk.sv =====
`include "gaussian_blur_square_kernel_2d_top_macros.svh"

module gbk_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input gbk_pkg::pix_t out_value,
  input gbk_pkg::col_t out_col,
  input gbk_pkg::row_t out_row,
  input logic          out_last
);

  logic held;
  logic [gbk_pkg::PIXEL_BITS+gbk_pkg::COL_W+gbk_pkg::ROW_W:0] out_payload;

  assign held        = out_valid && !out_ready;
  assign out_payload = {out_value, out_col, out_row, out_last};

  // a held result keeps its payload
  `GBK_ASSERT_NXT(a_out_hold, held, out_valid && $stable(out_payload), "held result changed")

  // input is only back-pressured by a held result
  `GBK_ASSERT_IMP(a_ready_free, !held, in_ready, "input stalled without a held result")

  // reset empties the pipeline
  `GBK_ASSERT_RST(a_rst_empty, !rst_n, !out_valid, "result shown right after reset")

endmodule

bind gaussian_blur_square_kernel_2d_top gbk_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.blurred_value),
  .out_col   (out_ch.center_col),
  .out_row   (out_ch.center_row),
  .out_last  (out_ch.frame_last)
);

// ===== bench/tb_top.sv =====
module tb_top;

  localparam logic [gbk_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int WDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    gbk_pkg::pix_t value;
    gbk_pkg::col_t col;
    gbk_pkg::row_t row;
    logic          last;
  } blur_res_t;

  // unsigned q1.16 gaussian taps by radius, |dy|, |dx|
  localparam int unsigned GAUSS_TAP [4][4][4] = '{
    '{'{65536, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
    '{'{21752, 8002, 0, 0}, '{8002, 2944, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
    '{'{10624, 6444, 1438, 0}, '{6444, 3908, 872, 0}, '{1438, 872, 195, 0},
      '{0, 0, 0, 0}},
    '{'{7000, 5016, 1845, 348}, '{5016, 3594, 1322, 250}, '{1845, 1322, 486, 92},
      '{348, 250, 92, 17}}
  };

  logic clk;
  logic rst_n;

  gbk_in_if  in_ch ();
  gbk_out_if out_ch ();
  gbk_cfg_if cfg_ch ();

  gaussian_blur_square_kernel_2d_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // blur predictor state
  gbk_pkg::pix_t line_mem [gbk_pkg::LINES][gbk_pkg::MAX_WIDTH];
  gbk_pkg::pix_t win_mem [gbk_pkg::WIN][gbk_pkg::WIN];
  int unsigned   pos_col;
  int unsigned   pos_row;
  int unsigned   set_radius;
  int unsigned   set_width;
  int unsigned   set_height;

  blur_res_t   blur_queue[$];
  int          fail_count;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    return (v > 1024) ? 1024 : v;
  endfunction

  // one pixel through the line store and window, expected result queued on emission
  task automatic blur_step(gbk_pkg::pix_t pix, bit fs);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned rw;
    int unsigned ctr;
    int unsigned lo;
    int unsigned di;
    int unsigned dj;
    longint unsigned acc;
    gbk_pkg::pix_t colv [gbk_pkg::WIN];
    blur_res_t res;
    w = clamp_dim(set_width);
    h = clamp_dim(set_height);
    r = set_radius & 3;
    if (fs) begin
      pos_col = 0;
      pos_row = 0;
    end
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    c = pos_col;
    rw = pos_row;
    for (int i = 0; i < gbk_pkg::LINES; i++) colv[i] = line_mem[i][c];
    colv[gbk_pkg::LINES] = pix;
    for (int i = 0; i + 1 < gbk_pkg::LINES; i++) line_mem[i][c] = line_mem[i+1][c];
    line_mem[gbk_pkg::LINES-1][c] = pix;
    for (int i = 0; i < gbk_pkg::WIN; i++) begin
      for (int j = 0; j + 1 < gbk_pkg::WIN; j++) win_mem[i][j] = win_mem[i][j+1];
      win_mem[i][gbk_pkg::WIN-1] = colv[i];
    end
    if (c >= 2 * r && rw >= 2 * r) begin
      ctr = gbk_pkg::LINES - r;
      lo = gbk_pkg::LINES - 2 * r;
      acc = 0;
      for (int unsigned i = lo; i < gbk_pkg::WIN; i++) begin
        for (int unsigned j = lo; j < gbk_pkg::WIN; j++) begin
          di = (i > ctr) ? i - ctr : ctr - i;
          dj = (j > ctr) ? j - ctr : ctr - j;
          acc += longint'(GAUSS_TAP[r][di & 3][dj & 3]) * longint'(win_mem[i][j]);
        end
      end
      acc = (acc + 64'h8000) >> 16;
      res.value = (acc > 65535) ? 16'hFFFF : acc[15:0];
      res.col = gbk_pkg::col_t'(c - r);
      res.row = gbk_pkg::row_t'(rw - r);
      res.last = (c == w - 1 && rw == h - 1);
      blur_queue.push_back(res);
    end
    pos_col = c + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = rw + 1;
      if (pos_row >= h) pos_row = 0;
    end
  endtask

  task automatic send_pixel(gbk_pkg::pix_t pix, bit fs);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel_value <= pix;
    in_ch.frame_start <= fs;
    do @(posedge clk); while (!in_ch.ready);
    blur_step(pix, fs);
  endtask

  // stop sending, let every pending result out, then let the pipeline settle
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (blur_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [gbk_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= gbk_pkg::CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      gbk_pkg::CFG_RADIUS: set_radius = val & 3;
      gbk_pkg::CFG_WIDTH:  set_width = val & 11'h7FF;
      gbk_pkg::CFG_HEIGHT: set_height = val & 11'h7FF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned r, int unsigned w, int unsigned h);
    drain();
    write_reg(gbk_pkg::CFG_RADIUS, r);
    write_reg(gbk_pkg::CFG_WIDTH, w);
    write_reg(gbk_pkg::CFG_HEIGHT, h);
  endtask

  function automatic gbk_pkg::pix_t rand_pixel();
    case ($urandom_range(9))
      0: return 16'h0000;
      1, 2: return 16'hFFFF;
      default: return gbk_pkg::pix_t'($urandom);
    endcase
  endfunction

  task automatic test_directed;
    // passthrough at radius zero, value extremes, frame end on a tiny image
    set_geometry(0, 2, 2);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'h7FFE, 1'b0);
    // saturation with a flat white field at full radius
    set_geometry(3, 7, 7);
    for (int k = 0; k < 7 * 7; k++) send_pixel(16'hFFFF, k == 0);
    // zero size acts as one, oversize saturates
    set_geometry(1, 0, 0);
    send_pixel(16'h1234, 1'b1);
    drain();
    write_reg(gbk_pkg::CFG_RADIUS, 0);
    send_pixel(16'hABCD, 1'b0);
    drain();
    write_reg(gbk_pkg::CFG_WIDTH, 2047);
    write_reg(gbk_pkg::CFG_HEIGHT, 2047);
    send_pixel(16'h5555, 1'b1);
    // unknown register index is ignored
    drain();
    write_reg(CFG_SPARE, 11'h7FF);
    send_pixel(16'hAAAA, 1'b0);
    // shrink width mid-row so the column is past the new bound
    set_geometry(0, 8, 4);
    for (int k = 0; k < 6; k++) send_pixel(rand_pixel(), k == 0);
    drain();
    write_reg(gbk_pkg::CFG_WIDTH, 3);
    for (int k = 0; k < 5; k++) send_pixel(rand_pixel(), 1'b0);
    // restart mid-frame
    send_pixel(16'h0F0F, 1'b1);
    send_pixel(16'hF0F0, 1'b0);
  endtask

  task automatic test_random_frames(int unsigned n_items);
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(3);
      w = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(2 * r + 1, 16);
      h = $urandom_range(1, 12);
      if ($urandom_range(5) != 0) set_geometry(r, w, h);
      len = clamp_dim(set_width) * clamp_dim(set_height);
      if (len > 200) len = 200;
      // mostly whole frames; some cut short or with a stray restart
      if ($urandom_range(7) == 0) len = $urandom_range(1, len);
      for (int unsigned k = 0; k < len; k++) begin
        send_pixel(rand_pixel(), k == 0 || $urandom_range(49) == 0);
      end
      sent += len;
      if ($urandom_range(9) == 0) drain();
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    blur_res_t exp_res;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (blur_queue.size() == 0) begin
          $display("%0t: unexpected transaction value=%h col=%0d row=%0d last=%b", $time,
                   out_ch.blurred_value, out_ch.center_col, out_ch.center_row,
                   out_ch.frame_last);
          fail_count++;
        end else begin
          exp_res = blur_queue.pop_front();
          if (out_ch.blurred_value !== exp_res.value || out_ch.center_col !== exp_res.col ||
              out_ch.center_row !== exp_res.row || out_ch.frame_last !== exp_res.last) begin
            $display("%0t: mismatch expected value=%h col=%0d row=%0d last=%b", $time,
                     exp_res.value, exp_res.col, exp_res.row, exp_res.last);
            $display("%0t:          actual   value=%h col=%0d row=%0d last=%b", $time,
                     out_ch.blurred_value, out_ch.center_col, out_ch.center_row,
                     out_ch.frame_last);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    fail_count = 0;
    quiet_cycles = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    pos_col = 0;
    pos_row = 0;
    set_radius = 1;
    set_width = 1024;
    set_height = 1024;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.pixel_value <= '0;
    in_ch.frame_start <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= gbk_pkg::CFG_RADIUS;
    cfg_ch.data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 26;
    receiver_stall_pct = 63;
    test_directed();
    test_random_frames(310);
    sender_idle_pct = 63;
    receiver_stall_pct = 26;
    test_random_frames(310);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    test_random_frames(310);
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gbk_pkg.sv
rtl/core/gbk_stream_if.sv
rtl/core/gbk_ram.sv
rtl/core/gbk_ctrl.sv
rtl/core/gbk_window.sv
rtl/core/gbk_mac.sv
rtl/core/gaussian_blur_square_kernel_2d_top.sv
rtl/core/gbk_chk.sv
bench/tb_top.sv
